// File: sv/osh_pkg.sv
// ----------------------------------------------------------------------------
// osh_pkg
// Shared types, constants and functions of the one-at-a-time string hash.
// ----------------------------------------------------------------------------
package osh_pkg;

  localparam int unsigned MixLeftShift  = 10;
  localparam int unsigned MixRightShift = 6;
  localparam int unsigned FinLeftShiftA = 3;
  localparam int unsigned FinRightShift = 11;
  localparam int unsigned FinLeftShiftB = 15;
  localparam logic [31:0] MinHash       = 32'd2;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] UpperFirst = 8'h41;
  localparam logic [7:0] UpperLast  = 8'h5A;
  localparam logic [7:0] CaseOffset = 8'h20;

  typedef struct packed {
    logic [7:0] folded_byte;
    logic       present;
    logic       last;
  } op_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= UpperFirst && b <= UpperLast) begin
      r = b + CaseOffset;
    end
    return r;
  endfunction

endpackage

// File: sv/osh_front.sv
// ----------------------------------------------------------------------------
// osh_front
// Accepts input bytes, folds case, drops empty items and registers the op.
// ----------------------------------------------------------------------------
module osh_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  logic [7:0]    char_byte,
  input  logic          byte_present,
  input  logic          end_of_string,
  output logic          op_valid,
  input  logic          op_full,
  output osh_pkg::op_t  op
);
  import osh_pkg::*;

  logic accept;
  logic push;

  assign push       = op_valid && !op_full;
  assign item_stall = op_valid && op_full;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (accept) begin
      // drop items that carry neither a byte nor the marker
      op_valid <= byte_present || end_of_string;
    end else if (push) begin
      op_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op.folded_byte <= fold_byte(char_byte);
      op.present     <= byte_present;
      op.last        <= end_of_string;
    end
  end

endmodule

// File: sv/osh_queue.sv
// ----------------------------------------------------------------------------
// osh_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module osh_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          full,
  input  osh_pkg::op_t  push_op,
  output logic          pop_valid,
  input  logic          pop,
  output osh_pkg::op_t  pop_op
);
  import osh_pkg::*;

  op_t                  entries [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (count == QueueCntW'(QueueDepth));
  assign pop_valid = (count != '0);
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

// File: sv/osh_back.sv
// ----------------------------------------------------------------------------
// osh_back
// Mixes bytes into the running hash, finalizes on end of string and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module osh_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_pop,
  input  osh_pkg::op_t  op,
  output logic          hash_valid,
  input  logic          hash_stall,
  output logic [31:0]   hash_value
);
  import osh_pkg::*;

  logic [31:0] running_hash;
  logic [31:0] fin_hash;
  logic        fin_valid;
  logic [31:0] h_add;
  logic [31:0] h_sum;
  logic [31:0] h_mix;
  logic [31:0] h_cur;
  logic        out_ready;
  logic        fin_ready;

  function automatic logic [31:0] finish(input logic [31:0] h);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = h + (h << FinLeftShiftA);
    b = a ^ (a >> FinRightShift);
    c = b + (b << FinLeftShiftB);
    if (c < MinHash) begin
      c = c + MinHash;
    end
    return c;
  endfunction

  assign h_add = running_hash + {{24{op.folded_byte[7]}}, op.folded_byte};
  assign h_sum = h_add + (h_add << MixLeftShift);
  assign h_mix = h_sum ^ (h_sum >> MixRightShift);
  assign h_cur = op.present ? h_mix : running_hash;

  assign out_ready = !hash_valid || !hash_stall;
  assign fin_ready = !fin_valid || out_ready;
  assign op_pop    = op_valid && (!op.last || fin_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      fin_valid    <= 1'b0;
      hash_valid   <= 1'b0;
    end else begin
      if (op_pop) begin
        running_hash <= op.last ? '0 : h_cur;
      end
      if (op_pop && op.last) begin
        fin_valid <= 1'b1;
      end else if (out_ready) begin
        fin_valid <= 1'b0;
      end
      if (out_ready) begin
        hash_valid <= fin_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop && op.last) begin
      fin_hash <= h_cur;
    end
    if (out_ready && fin_valid) begin
      hash_value <= finish(fin_hash);
    end
  end

endmodule

// File: sv/one_at_a_time_string_hash.sv
// ----------------------------------------------------------------------------
// one_at_a_time_string_hash
// Case-folding 32-bit one-at-a-time string hash, one byte per transfer.
//
//   channel  valid       stall       payload
//   input    item_valid  item_stall  char_byte, byte_present, end_of_string
//   output   hash_valid  hash_stall  hash_value
//
// One byte per cycle sustained while neither side stalls; the mix of each
// byte feeds back through the running-hash register in the back end. After
// its end-of-string transfer a hash passes the front op register, a queue
// entry, the finalize register and the output register. Synchronous reset
// clears the running hash and all valid flags. Either side may stall on its
// own; a two-entry queue between front and back absorbs the difference.
// ----------------------------------------------------------------------------
module one_at_a_time_string_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  char_byte,
  input  logic        byte_present,
  input  logic        end_of_string,
  output logic        hash_valid,
  input  logic        hash_stall,
  output logic [31:0] hash_value
);
  import osh_pkg::*;

  op_t  front_op;
  op_t  queue_op;
  logic front_valid;
  logic queue_full;
  logic queue_valid;
  logic queue_pop;

  osh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .char_byte     (char_byte),
    .byte_present  (byte_present),
    .end_of_string (end_of_string),
    .op_valid      (front_valid),
    .op_full       (queue_full),
    .op            (front_op)
  );

  osh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .full       (queue_full),
    .push_op    (front_op),
    .pop_valid  (queue_valid),
    .pop        (queue_pop),
    .pop_op     (queue_op)
  );

  osh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (queue_valid),
    .op_pop     (queue_pop),
    .op         (queue_op),
    .hash_valid (hash_valid),
    .hash_stall (hash_stall),
    .hash_value (hash_value)
  );

endmodule
